[hw/rtl/dgas_pkg.sv]
// ----------------------------------------------------------------------------
// dgas_pkg: shared types and constants of the directed graph adjacency store
// Sizes of the node table and entry pool, request/result structs, codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dgas_pkg;

  // Sizes
  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 128;
  localparam int POOL_SIZE = 2 * MAX_EDGES;

  localparam int NODE_W   = 7;                        // node id field
  localparam int NODE_AW  = $clog2(MAX_NODES);        // node table index
  localparam int HEAD_AW  = NODE_AW + 1;              // {direction, node}
  localparam int IDX_W    = $clog2(POOL_SIZE + 1);    // pool index incl. null
  localparam int POOL_AW  = $clog2(POOL_SIZE);        // pool memory address
  localparam int ENTRY_W  = NODE_W + IDX_W;           // {next, id}

  localparam logic [IDX_W-1:0] NIL_IDX = IDX_W'(POOL_SIZE);

  // Command codes
  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_LIST_OUT = 2'd1;
  localparam logic [1:0] CMD_LIST_IN  = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_DUP   = 3'd2;
  localparam logic [2:0] ST_BAD   = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  // Head table direction select
  localparam logic DIR_OUT = 1'b0;
  localparam logic DIR_IN  = 1'b1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] neighbor;
    logic [2:0]        status;
    logic              last;
  } out_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_FULL,
    S_ADD_IN,
    S_LIST,
    S_REPLY
  } state_e;

endpackage

`default_nettype wire

[hw/rtl/directed_graph_adjacency_store.sv]
// ----------------------------------------------------------------------------
// directed_graph_adjacency_store: linked-list adjacency store for a digraph
// Per-node outgoing/incoming lists in a shared entry pool, walked by a
// small sequencer with one id comparator.
// ----------------------------------------------------------------------------
// Usage: one request at a time; in_ready_o is high only while the sequencer
// is idle, and a finished result may still sit in the output register then.
// Timing is set by the pool memory's registered read port, one entry per
// cycle, in a list only while the output is not stalled: an add walks the
// source's outgoing entries and then links the edge into both lists, or
// stops at a duplicate, and a list request reports each neighbor, at most
// 64 of them. A bad id goes from idle straight to the reply state, where its
// result is registered. Output stalls hold the sequencer in the list and
// reply states. No clearing pass: head valid bits reset at once and only
// allocated pool entries are ever read. node_count is written through the
// cfg channel, which is always ready; values above 64 saturate.
`default_nettype none

module directed_graph_adjacency_store
  import dgas_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_req_t           in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_res_t               out_res_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [NODE_W-1:0] cfg_data_i
);

  // Registers
  state_e                state_q, state_d;
  in_req_t               req_q;
  logic [IDX_W-1:0]      p_q;           // old outgoing head during an add
  logic [NODE_AW-1:0]    cnt_q;         // neighbors reported so far
  logic [2:0]            stat_q;
  logic [IDX_W-1:0]      pool_used_q;
  logic [NODE_W-1:0]     node_count_q;
  logic                  out_valid_q;
  out_res_t              out_q;

  // Head table and pool memories
  logic [IDX_W-1:0]      head_mem [2*MAX_NODES];
  logic [2*MAX_NODES-1:0] vld_q;
  logic [HEAD_AW-1:0]    head_addr_q;
  logic [IDX_W-1:0]      head_rdata_q;
  logic [ENTRY_W-1:0]    pool_mem [POOL_SIZE];
  logic [ENTRY_W-1:0]    pool_rdata_q;

  // Control
  logic                  accept;
  logic                  a_ok, b_ok, bad;
  logic                  out_free;
  logic [IDX_W-1:0]      head_p;
  logic [NODE_W-1:0]     e_id;
  logic [IDX_W-1:0]      e_nx;
  logic                  id_hit;
  logic                  pool_full;
  logic                  fin;

  logic                  head_re, head_we;
  logic [HEAD_AW-1:0]    head_raddr, head_waddr;
  logic [IDX_W-1:0]      head_wdata;
  logic                  pool_re, pool_we;
  logic [IDX_W-1:0]      pool_rptr;
  logic [IDX_W-1:0]      pool_wptr;
  logic [ENTRY_W-1:0]    pool_wdata;
  logic                  p_we, cnt_clr, cnt_inc, stat_we, used_inc;
  logic [2:0]            stat_d;
  logic                  out_load;
  out_res_t              out_d;

  // Node index of a 1-based id
  function automatic logic [NODE_AW-1:0] node_idx(input logic [NODE_W-1:0] id);
    logic [NODE_W-1:0] m;
    m = id - NODE_W'(1);
    return m[NODE_AW-1:0];
  endfunction

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Id range check on the incoming request
  assign a_ok = (in_req_i.node_a != '0) && (in_req_i.node_a <= node_count_q);
  assign b_ok = (in_req_i.node_b != '0) && (in_req_i.node_b <= node_count_q);
  assign bad  = !a_ok || ((in_req_i.cmd == CMD_ADD) && !b_ok);

  // Shared compare unit and decoded pool entry
  assign head_p    = vld_q[head_addr_q] ? head_rdata_q : NIL_IDX;
  assign e_id      = pool_rdata_q[NODE_W-1:0];
  assign e_nx      = pool_rdata_q[ENTRY_W-1:NODE_W];
  assign id_hit    = (e_id == req_q.node_b);
  assign pool_full = (pool_used_q > IDX_W'(POOL_SIZE - 2));
  assign fin       = (e_nx == NIL_IDX) || (cnt_q == NODE_AW'(MAX_NODES - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && in_req_i.cmd != CMD_NONE) begin
          state_d = bad ? S_REPLY : S_HEAD;
        end
      end
      S_HEAD: begin
        if (req_q.cmd == CMD_ADD) begin
          state_d = (head_p == NIL_IDX) ? S_FULL : S_WALK;
        end else begin
          state_d = (head_p == NIL_IDX) ? S_REPLY : S_LIST;
        end
      end
      S_WALK: begin
        if (id_hit) begin
          state_d = S_REPLY;
        end else if (e_nx == NIL_IDX) begin
          state_d = S_FULL;
        end
      end
      S_FULL: begin
        state_d = pool_full ? S_REPLY : S_ADD_IN;
      end
      S_ADD_IN: begin
        state_d = S_REPLY;
      end
      S_LIST: begin
        if (out_free && fin) begin
          state_d = S_IDLE;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    head_re    = 1'b0;
    head_raddr = '0;
    head_we    = 1'b0;
    head_waddr = '0;
    head_wdata = '0;
    pool_re    = 1'b0;
    pool_rptr  = '0;
    pool_we    = 1'b0;
    pool_wptr  = pool_used_q;
    pool_wdata = '0;
    p_we       = 1'b0;
    cnt_clr    = 1'b0;
    cnt_inc    = 1'b0;
    stat_we    = 1'b0;
    stat_d     = ST_OK;
    used_inc   = 1'b0;
    out_load   = 1'b0;
    out_d      = '{neighbor: '0, status: stat_q, last: 1'b1};
    case (state_q)
      S_IDLE: begin
        if (accept && in_req_i.cmd != CMD_NONE) begin
          if (bad) begin
            stat_we = 1'b1;
            stat_d  = ST_BAD;
          end else begin
            head_re    = 1'b1;
            head_raddr = {(in_req_i.cmd == CMD_LIST_IN) ? DIR_IN : DIR_OUT,
                          node_idx(in_req_i.node_a)};
          end
        end
      end
      S_HEAD: begin
        cnt_clr = 1'b1;
        p_we    = 1'b1;
        if (head_p == NIL_IDX) begin
          if (req_q.cmd != CMD_ADD) begin
            stat_we = 1'b1;
            stat_d  = ST_EMPTY;
          end
        end else begin
          pool_re   = 1'b1;
          pool_rptr = head_p;
        end
      end
      S_WALK: begin
        if (id_hit) begin
          stat_we = 1'b1;
          stat_d  = ST_DUP;
        end else if (e_nx != NIL_IDX) begin
          pool_re   = 1'b1;
          pool_rptr = e_nx;
        end
      end
      S_FULL: begin
        if (pool_full) begin
          stat_we = 1'b1;
          stat_d  = ST_FULL;
        end else begin
          // link target at the front of the source's outgoing list
          pool_we    = 1'b1;
          pool_wdata = {p_q, req_q.node_b};
          head_we    = 1'b1;
          head_waddr = {DIR_OUT, node_idx(req_q.node_a)};
          head_wdata = pool_used_q;
          used_inc   = 1'b1;
          head_re    = 1'b1;
          head_raddr = {DIR_IN, node_idx(req_q.node_b)};
        end
      end
      S_ADD_IN: begin
        // link source at the front of the target's incoming list
        pool_we    = 1'b1;
        pool_wdata = {head_p, req_q.node_a};
        head_we    = 1'b1;
        head_waddr = {DIR_IN, node_idx(req_q.node_b)};
        head_wdata = pool_used_q;
        used_inc   = 1'b1;
        stat_we    = 1'b1;
        stat_d     = ST_OK;
      end
      S_LIST: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{neighbor: e_id, status: ST_OK, last: fin};
          if (!fin) begin
            pool_re   = 1'b1;
            pool_rptr = e_nx;
            cnt_inc   = 1'b1;
          end
        end
      end
      S_REPLY: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pool_used_q  <= '0;
      node_count_q <= NODE_W'(MAX_NODES);
      out_valid_q  <= 1'b0;
      vld_q        <= '0;
    end else begin
      state_q <= state_d;
      if (used_inc) begin
        pool_used_q <= pool_used_q + IDX_W'(1);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        node_count_q <= (cfg_data_i > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES)
                                                          : cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (head_we) begin
        vld_q[head_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    if (p_we) begin
      p_q <= head_p;
    end
    if (cnt_clr) begin
      cnt_q <= '0;
    end else if (cnt_inc) begin
      cnt_q <= cnt_q + NODE_AW'(1);
    end
    if (stat_we) begin
      stat_q <= stat_d;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Head table memory
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rdata_q <= head_mem[head_raddr];
      head_addr_q  <= head_raddr;
    end
  end

  // Entry pool memory
  always_ff @(posedge clk_i) begin
    if (pool_we) begin
      pool_mem[pool_wptr[POOL_AW-1:0]] <= pool_wdata;
    end
    if (pool_re) begin
      pool_rdata_q <= pool_mem[pool_rptr[POOL_AW-1:0]];
    end
  end

  // Assertions
  a_pool_rd_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_re |-> (pool_rptr < pool_used_q))
    else $error("pool read of an unallocated entry");

  a_pool_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_we |-> ((state_q == S_FULL) || (state_q == S_ADD_IN)))
    else $error("pool write outside the link steps");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_used_q <= IDX_W'(POOL_SIZE))
    else $error("pool allocation beyond its size");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == ST_EMPTY)) |-> (out_q.last && (out_q.neighbor == '0)))
    else $error("empty-list result malformed");

endmodule

`default_nettype wire
